[hdl/lar_pkg.sv]
package lar_pkg;

    localparam int IN_W          = 32;
    localparam int OUT_W         = 16;
    localparam int UNIT_BITS     = 30;
    localparam int OUT_FRAC_BITS = 14;
    localparam int RED_BITS      = 20;

    // Normalizer datapath sizes
    localparam int RAD_W       = 62;
    localparam int ROOT_W      = 31;
    localparam int SQ_STEPS    = 31;
    localparam int DV_STEPS    = 32;
    localparam int RED_SPAN    = 34;
    localparam int NORM_STAGES = 72;

    localparam int          OUT_SHIFT = UNIT_BITS - OUT_FRAC_BITS;
    localparam logic [32:0] OUT_RND   = 33'((64'(1) << OUT_SHIFT) >> 1);

    typedef logic [2:0][63:0]     vec64_t;
    typedef logic [2:0][IN_W-1:0] unit3_t;
    typedef logic [6*IN_W-1:0]    side_t;

    typedef struct packed {
        logic valid;
        logic ok;
    } ctl_t;

    // Q30 to output format, round half away from zero, keep low bits
    function automatic logic [OUT_W-1:0] to_out(input logic [IN_W-1:0] v);
        logic [32:0] m;
        logic [32:0] r;
        m = v[IN_W-1] ? 33'(-{1'b1, v}) : {1'b0, v};
        r = (m + OUT_RND) >> OUT_SHIFT;
        if (v[IN_W-1]) begin
            r = -r;
        end
        return r[OUT_W-1:0];
    endfunction

endpackage

[hdl/lar_norm.sv]
module lar_norm (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  lar_pkg::ctl_t   in_ctl,
    input  lar_pkg::vec64_t in_vec,
    input  lar_pkg::side_t  in_side,
    output lar_pkg::ctl_t   out_ctl,
    output lar_pkg::unit3_t out_unit,
    output lar_pkg::side_t  out_side
);
    import lar_pkg::*;

    typedef struct packed {
        ctl_t       ctl;
        side_t      side;
        logic [2:0] neg;
    } hdr_t;

    hdr_t hdr_reg  [NORM_STAGES];
    hdr_t hdr_next [NORM_STAGES];

    logic [2:0][63:0]         mag_reg [4];
    logic [63:0]              max_next;
    logic [63:0]              max_reg;
    logic [7:0]               grp_nz_reg;
    logic [7:0][3:0]          grp_len_reg;
    logic [6:0]               blen_next;
    logic [6:0]               blen_reg;
    logic [2:0][RED_BITS-1:0] red_next;
    logic [2:0][RED_BITS-1:0] red_reg [RED_SPAN];
    logic [2:0][2*RED_BITS-1:0] sq_reg;
    logic [RAD_W-1:0]         rad_reg;

    logic [32:0]       sr_rem_in   [SQ_STEPS];
    logic [ROOT_W-1:0] sr_root_in  [SQ_STEPS];
    logic [RAD_W-1:0]  sr_rad_in   [SQ_STEPS];
    logic [32:0]       sr_rem_next [SQ_STEPS];
    logic [ROOT_W-1:0] sr_root_next[SQ_STEPS];
    logic [32:0]       sr_rem_reg  [SQ_STEPS];
    logic [ROOT_W-1:0] sr_root_reg [SQ_STEPS];
    logic [RAD_W-1:0]  sr_rad_reg  [SQ_STEPS];

    logic [2:0][60:0]  num_sum;
    logic [2:0][28:0]  num_hi_reg;
    logic [2:0][31:0]  num_lo_reg;
    logic [ROOT_W-1:0] num_len_reg;

    logic [2:0][30:0]  dv_rem_in   [DV_STEPS];
    logic [2:0][31:0]  dv_lo_in    [DV_STEPS];
    logic [2:0][31:0]  dv_q_in     [DV_STEPS];
    logic [ROOT_W-1:0] dv_len_in   [DV_STEPS];
    logic [2:0][30:0]  dv_rem_next [DV_STEPS];
    logic [2:0][31:0]  dv_q_next   [DV_STEPS];
    logic [2:0][30:0]  dv_rem_reg  [DV_STEPS];
    logic [2:0][31:0]  dv_lo_reg   [DV_STEPS];
    logic [2:0][31:0]  dv_q_reg    [DV_STEPS];
    logic [ROOT_W-1:0] dv_len_reg  [DV_STEPS];

    unit3_t unit_next;
    unit3_t unit_reg;

    function automatic logic [3:0] byte_len(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

    // Header line: valid, ok, side data and signs travel with the item
    always_comb begin
        hdr_next[0].ctl  = in_ctl;
        hdr_next[0].side = in_side;
        for (int i = 0; i < 3; i++) begin
            hdr_next[0].neg[i] = in_vec[i][63];
        end
        for (int k = 1; k < NORM_STAGES; k++) begin
            hdr_next[k] = hdr_reg[k-1];
        end
        // drop ok when the vector is zero
        hdr_next[3].ctl.ok = hdr_reg[2].ctl.ok & (|grp_nz_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NORM_STAGES; k++) begin
                hdr_reg[k].ctl.valid <= 1'b0;
            end
        end else if (en) begin
            for (int k = 0; k < NORM_STAGES; k++) begin
                hdr_reg[k] <= hdr_next[k];
            end
        end
    end

    always_comb begin
        max_next = mag_reg[0][0];
        if (mag_reg[0][1] > max_next) begin
            max_next = mag_reg[0][1];
        end
        if (mag_reg[0][2] > max_next) begin
            max_next = mag_reg[0][2];
        end
    end

    always_comb begin
        blen_next = '0;
        for (int g = 0; g < 8; g++) begin
            if (grp_nz_reg[g]) begin
                blen_next = 7'(8 * g) + 7'(grp_len_reg[g]);
            end
        end
    end

    // Bring the largest magnitude into [2^19, 2^20)
    always_comb begin
        logic [63:0] sh;
        for (int i = 0; i < 3; i++) begin
            if (blen_reg > 7'(RED_BITS)) begin
                sh = mag_reg[3][i] >> (blen_reg - 7'(RED_BITS));
            end else begin
                sh = mag_reg[3][i] << (7'(RED_BITS) - blen_reg);
            end
            red_next[i] = sh[RED_BITS-1:0];
        end
    end

    // Square root, one result bit per stage
    always_comb begin
        logic [34:0] trial;
        logic [34:0] tq;
        sr_rem_in[0]  = '0;
        sr_root_in[0] = '0;
        sr_rad_in[0]  = rad_reg;
        for (int s = 1; s < SQ_STEPS; s++) begin
            sr_rem_in[s]  = sr_rem_reg[s-1];
            sr_root_in[s] = sr_root_reg[s-1];
            sr_rad_in[s]  = sr_rad_reg[s-1];
        end
        for (int s = 0; s < SQ_STEPS; s++) begin
            trial = {sr_rem_in[s], sr_rad_in[s][RAD_W-1-2*s -: 2]};
            tq    = {2'b00, sr_root_in[s], 2'b01};
            if (trial >= tq) begin
                sr_rem_next[s]  = 33'(trial - tq);
                sr_root_next[s] = {sr_root_in[s][ROOT_W-2:0], 1'b1};
            end else begin
                sr_rem_next[s]  = trial[32:0];
                sr_root_next[s] = {sr_root_in[s][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num_sum[i] = {1'b0, red_reg[RED_SPAN-1][i], 40'b0}
                       + 61'(sr_root_reg[SQ_STEPS-1][ROOT_W-1:1]);
        end
    end

    // Restoring division, one quotient bit per stage
    always_comb begin
        logic [31:0] r;
        dv_len_in[0] = num_len_reg;
        for (int i = 0; i < 3; i++) begin
            dv_rem_in[0][i] = {2'b00, num_hi_reg[i]};
        end
        dv_lo_in[0] = num_lo_reg;
        dv_q_in[0]  = '0;
        for (int j = 1; j < DV_STEPS; j++) begin
            dv_rem_in[j] = dv_rem_reg[j-1];
            dv_lo_in[j]  = dv_lo_reg[j-1];
            dv_q_in[j]   = dv_q_reg[j-1];
            dv_len_in[j] = dv_len_reg[j-1];
        end
        for (int j = 0; j < DV_STEPS; j++) begin
            for (int i = 0; i < 3; i++) begin
                r = {dv_rem_in[j][i], dv_lo_in[j][i][31-j]};
                if (r >= {1'b0, dv_len_in[j]}) begin
                    dv_rem_next[j][i] = 31'(r - {1'b0, dv_len_in[j]});
                    dv_q_next[j][i]   = {dv_q_in[j][i][30:0], 1'b1};
                end else begin
                    dv_rem_next[j][i] = r[30:0];
                    dv_q_next[j][i]   = {dv_q_in[j][i][30:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        logic [31:0] q;
        for (int i = 0; i < 3; i++) begin
            q = dv_q_reg[DV_STEPS-1][i];
            if (q > 32'(1 << UNIT_BITS)) begin
                q = 32'(1 << UNIT_BITS);
            end
            unit_next[i] = hdr_reg[NORM_STAGES-2].neg[i] ? -q : q;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[0][i] <= in_vec[i][63] ? -in_vec[i] : in_vec[i];
            end
            mag_reg[1] <= mag_reg[0];
            mag_reg[2] <= mag_reg[1];
            mag_reg[3] <= mag_reg[2];
            max_reg    <= max_next;
            for (int g = 0; g < 8; g++) begin
                grp_nz_reg[g]  <= |max_reg[8*g +: 8];
                grp_len_reg[g] <= byte_len(max_reg[8*g +: 8]);
            end
            blen_reg   <= blen_next;
            red_reg[0] <= red_next;
            for (int k = 1; k < RED_SPAN; k++) begin
                red_reg[k] <= red_reg[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= red_reg[0][i] * red_reg[0][i];
            end
            rad_reg <= {42'(sq_reg[0]) + 42'(sq_reg[1]) + 42'(sq_reg[2]), 20'b0};
            for (int s = 0; s < SQ_STEPS; s++) begin
                sr_rem_reg[s]  <= sr_rem_next[s];
                sr_root_reg[s] <= sr_root_next[s];
                sr_rad_reg[s]  <= sr_rad_in[s];
            end
            for (int i = 0; i < 3; i++) begin
                num_hi_reg[i] <= num_sum[i][60:32];
                num_lo_reg[i] <= num_sum[i][31:0];
            end
            num_len_reg <= sr_root_reg[SQ_STEPS-1];
            for (int j = 0; j < DV_STEPS; j++) begin
                dv_rem_reg[j] <= dv_rem_next[j];
                dv_q_reg[j]   <= dv_q_next[j];
                dv_lo_reg[j]  <= dv_lo_in[j];
                dv_len_reg[j] <= dv_len_in[j];
            end
            unit_reg <= unit_next;
        end
    end

    assign out_ctl  = hdr_reg[NORM_STAGES-1].ctl;
    assign out_side = hdr_reg[NORM_STAGES-1].side;
    assign out_unit = unit_reg;

endmodule

[hdl/look_at_rotation_basis_unit.sv]
// Throughput: one beat per cycle; each of the three normalizers is a
// 72-stage line (31 square-root steps, 32 divide steps), and every stage
// advances whenever the output register is empty or being taken.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
module look_at_rotation_basis_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [lar_pkg::IN_W-1:0]   s_pos_x,
    input  logic signed [lar_pkg::IN_W-1:0]   s_pos_y,
    input  logic signed [lar_pkg::IN_W-1:0]   s_pos_z,
    input  logic signed [lar_pkg::IN_W-1:0]   s_target_x,
    input  logic signed [lar_pkg::IN_W-1:0]   s_target_y,
    input  logic signed [lar_pkg::IN_W-1:0]   s_target_z,
    input  logic signed [lar_pkg::IN_W-1:0]   s_up_x,
    input  logic signed [lar_pkg::IN_W-1:0]   s_up_y,
    input  logic signed [lar_pkg::IN_W-1:0]   s_up_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [lar_pkg::OUT_W-1:0]  m_right_x,
    output logic signed [lar_pkg::OUT_W-1:0]  m_right_y,
    output logic signed [lar_pkg::OUT_W-1:0]  m_right_z,
    output logic signed [lar_pkg::OUT_W-1:0]  m_upc_x,
    output logic signed [lar_pkg::OUT_W-1:0]  m_upc_y,
    output logic signed [lar_pkg::OUT_W-1:0]  m_upc_z,
    output logic signed [lar_pkg::OUT_W-1:0]  m_fwd_x,
    output logic signed [lar_pkg::OUT_W-1:0]  m_fwd_y,
    output logic signed [lar_pkg::OUT_W-1:0]  m_fwd_z,
    output logic                              m_degenerate
);
    import lar_pkg::*;

    logic en;

    logic   in_valid_reg;
    vec64_t dir_reg;
    unit3_t up_reg;

    ctl_t   n1_ctl, n2_ctl, n3_ctl;
    unit3_t n1_unit, n2_unit, n3_unit;
    side_t  n1_side, n2_side, n3_side;

    ctl_t                        xa1_ctl_reg, xb1_ctl_reg, xa2_ctl_reg, xb2_ctl_reg;
    logic signed [2:0][1:0][63:0] xa1_prod_reg, xa2_prod_reg;
    logic signed [2:0][1:0][63:0] xa1_prod_next, xa2_prod_next;
    unit3_t                      xa1_keep_reg, xa2_rgt_reg, xa2_fwd_reg;
    vec64_t                      xb1_vec_reg, xb2_vec_reg;
    unit3_t                      xb1_keep_reg, xb2_rgt_reg, xb2_fwd_reg;

    logic                        out_valid_reg;
    logic [8:0][OUT_W-1:0]       out_reg;
    logic                        degen_reg;

    assign en      = ~out_valid_reg | m_ready;
    assign s_ready = en & aresetn;

    // Cross products: right = fwd x up, upc = rgt x fwd
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            xa1_prod_next[i][0] = $signed(n1_unit[(i+1)%3])
                                * $signed(n1_side[3*IN_W + ((i+2)%3)*IN_W +: IN_W]);
            xa1_prod_next[i][1] = $signed(n1_unit[(i+2)%3])
                                * $signed(n1_side[3*IN_W + ((i+1)%3)*IN_W +: IN_W]);
            xa2_prod_next[i][0] = $signed(n2_unit[(i+1)%3])
                                * $signed(n2_side[3*IN_W + ((i+2)%3)*IN_W +: IN_W]);
            xa2_prod_next[i][1] = $signed(n2_unit[(i+2)%3])
                                * $signed(n2_side[3*IN_W + ((i+1)%3)*IN_W +: IN_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            xa1_ctl_reg.valid <= 1'b0;
            xb1_ctl_reg.valid <= 1'b0;
            xa2_ctl_reg.valid <= 1'b0;
            xb2_ctl_reg.valid <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else if (en) begin
            in_valid_reg  <= s_valid;
            xa1_ctl_reg   <= n1_ctl;
            xb1_ctl_reg   <= xa1_ctl_reg;
            xa2_ctl_reg   <= n2_ctl;
            xb2_ctl_reg   <= xa2_ctl_reg;
            out_valid_reg <= n3_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dir_reg[0] <= 64'(s_target_x) - 64'(s_pos_x);
            dir_reg[1] <= 64'(s_target_y) - 64'(s_pos_y);
            dir_reg[2] <= 64'(s_target_z) - 64'(s_pos_z);
            up_reg     <= {s_up_z, s_up_y, s_up_x};

            xa1_prod_reg <= xa1_prod_next;
            xa1_keep_reg <= n1_unit;
            xa2_prod_reg <= xa2_prod_next;
            xa2_rgt_reg  <= n2_unit;
            xa2_fwd_reg  <= n2_side[6*IN_W-1:3*IN_W];
            for (int i = 0; i < 3; i++) begin
                xb1_vec_reg[i] <= xa1_prod_reg[i][0] - xa1_prod_reg[i][1];
                xb2_vec_reg[i] <= xa2_prod_reg[i][0] - xa2_prod_reg[i][1];
            end
            xb1_keep_reg <= xa1_keep_reg;
            xb2_rgt_reg  <= xa2_rgt_reg;
            xb2_fwd_reg  <= xa2_fwd_reg;

            degen_reg <= ~n3_ctl.ok;
            for (int i = 0; i < 3; i++) begin
                out_reg[i]   <= n3_ctl.ok ? to_out(n3_side[3*IN_W + i*IN_W +: IN_W]) : '0;
                out_reg[3+i] <= n3_ctl.ok ? to_out(n3_unit[i]) : '0;
                out_reg[6+i] <= n3_ctl.ok ? to_out(n3_side[i*IN_W +: IN_W]) : '0;
            end
        end
    end

    lar_norm u_norm_fwd (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_ctl   ('{valid: in_valid_reg, ok: 1'b1}),
        .in_vec   (dir_reg),
        .in_side  ({up_reg, {(3*IN_W){1'b0}}}),
        .out_ctl  (n1_ctl),
        .out_unit (n1_unit),
        .out_side (n1_side)
    );

    lar_norm u_norm_rgt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_ctl   (xb1_ctl_reg),
        .in_vec   (xb1_vec_reg),
        .in_side  ({xb1_keep_reg, {(3*IN_W){1'b0}}}),
        .out_ctl  (n2_ctl),
        .out_unit (n2_unit),
        .out_side (n2_side)
    );

    lar_norm u_norm_upc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_ctl   (xb2_ctl_reg),
        .in_vec   (xb2_vec_reg),
        .in_side  ({xb2_rgt_reg, xb2_fwd_reg}),
        .out_ctl  (n3_ctl),
        .out_unit (n3_unit),
        .out_side (n3_side)
    );

    assign m_valid      = out_valid_reg;
    assign m_right_x    = out_reg[0];
    assign m_right_y    = out_reg[1];
    assign m_right_z    = out_reg[2];
    assign m_upc_x      = out_reg[3];
    assign m_upc_y      = out_reg[4];
    assign m_upc_z      = out_reg[5];
    assign m_fwd_x      = out_reg[6];
    assign m_fwd_y      = out_reg[7];
    assign m_fwd_z      = out_reg[8];
    assign m_degenerate = degen_reg;

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lar_pkg::*;

    localparam int N_RANDOM    = 450;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 700;
    localparam int TAIL_CYCLES = 300;

    typedef logic signed [IN_W-1:0] coord_t;
    typedef longint signed          qvec_t[3];

    typedef struct {
        coord_t     c[9];
        logic [OUT_W-1:0] m[9];
        logic       degen;
        bit         typed;
        bit         drain;
    } view_beat_t;

    typedef struct {
        logic [OUT_W-1:0] m[9];
        logic       degen;
    } basis_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    coord_t s_c[9] = '{default: '0};
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [OUT_W-1:0] m_f[9];
    logic m_degenerate;

    view_beat_t stim_q[$];
    basis_t     basis_q[$];
    int  n_direct;
    int  next_idx = 0;
    int  cycles   = 0;
    bit  failed   = 1'b0;
    int  hold_cnt = 0;
    bit  hold_done = 1'b0;

    string field_names[9] = '{"right_x", "right_y", "right_z", "upc_x", "upc_y", "upc_z",
                              "fwd_x", "fwd_y", "fwd_z"};

    always #1 aclk = ~aclk;

    look_at_rotation_basis_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_x(s_c[0]), .s_pos_y(s_c[1]), .s_pos_z(s_c[2]),
        .s_target_x(s_c[3]), .s_target_y(s_c[4]), .s_target_z(s_c[5]),
        .s_up_x(s_c[6]), .s_up_y(s_c[7]), .s_up_z(s_c[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_right_x(m_f[0]), .m_right_y(m_f[1]), .m_right_z(m_f[2]),
        .m_upc_x(m_f[3]), .m_upc_y(m_f[4]), .m_upc_z(m_f[5]),
        .m_fwd_x(m_f[6]), .m_fwd_y(m_f[7]), .m_fwd_z(m_f[8]),
        .m_degenerate(m_degenerate)
    );

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bit_w;
        res   = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > n) bit_w >>= 2;
        while (bit_w != 0) begin
            if (n >= res + bit_w) begin
                n   -= res + bit_w;
                res  = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    // Q30 unit vector; zero vector gives 0
    function automatic bit unit_q30(input qvec_t v, output qvec_t u);
        longint unsigned a[3];
        longint unsigned mx, s, len, q;
        int b;
        mx = 0;
        s  = 0;
        b  = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = v[i] < 0 ? -v[i] : v[i];
            if (a[i] > mx) mx = a[i];
        end
        u = '{0, 0, 0};
        if (mx == 0) return 1'b0;
        while (b < 64 && (mx >> b) != 0) b++;
        for (int i = 0; i < 3; i++) begin
            if (b > RED_BITS) a[i] >>= (b - RED_BITS);
            else a[i] <<= (RED_BITS - b);
            s += a[i] * a[i];
        end
        len = int_sqrt(s << 20);
        for (int i = 0; i < 3; i++) begin
            q = ((a[i] << 40) + (len >> 1)) / len;
            if (q > (64'd1 << UNIT_BITS)) q = 64'd1 << UNIT_BITS;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic void cross_prod(input qvec_t p, input qvec_t q, output qvec_t r);
        r[0] = p[1] * q[2] - p[2] * q[1];
        r[1] = p[2] * q[0] - p[0] * q[2];
        r[2] = p[0] * q[1] - p[1] * q[0];
    endfunction

    function automatic logic [OUT_W-1:0] q30_to_out(longint signed v);
        longint unsigned mg;
        int d;
        d  = UNIT_BITS - OUT_FRAC_BITS;
        mg = v < 0 ? -v : v;
        if (d > 0) mg = (mg + (64'd1 << (d - 1))) >> d;
        if (v < 0) mg = -mg;
        return mg[OUT_W-1:0];
    endfunction

    function automatic basis_t look_at_basis(input coord_t c[9]);
        qvec_t dir, up, fwd, rgt, upc, tmp;
        basis_t r;
        bit ok;
        for (int i = 0; i < 3; i++) begin
            dir[i] = longint'(c[3+i]) - longint'(c[i]);
            up[i]  = longint'(c[6+i]);
        end
        ok = unit_q30(dir, fwd);
        if (ok) begin
            cross_prod(fwd, up, tmp);
            ok = unit_q30(tmp, rgt);
        end
        if (ok) begin
            cross_prod(rgt, fwd, tmp);
            ok = unit_q30(tmp, upc);
        end
        r.degen = !ok;
        for (int i = 0; i < 3; i++) begin
            r.m[i]   = ok ? q30_to_out(rgt[i]) : '0;
            r.m[3+i] = ok ? q30_to_out(upc[i]) : '0;
            r.m[6+i] = ok ? q30_to_out(fwd[i]) : '0;
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [OUT_W-1:0] want,
                                        logic [OUT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            failed = 1'b1;
        end
    endfunction

    function automatic coord_t rand_coord(int kind);
        case (kind)
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(2000)) - 1000);
            2: return coord_t'($urandom) >>> $urandom_range(31);
            default: return coord_t'($signed($urandom_range(40)) - 20) <<< 16;
        endcase
    endfunction

    function automatic void add_row(coord_t c[9], bit typed, logic [OUT_W-1:0] m[9],
                                    logic degen, bit drain);
        view_beat_t b;
        b.c = c;
        b.m = m;
        b.degen = degen;
        b.typed = typed;
        b.drain = drain;
        stim_q.push_back(b);
    endfunction

    function automatic void build_stimulus();
        localparam coord_t MX = 32'sh7FFFFFFF;
        localparam coord_t MN = 32'sh80000000;
        localparam coord_t ONE = 32'sh00010000;
        logic [OUT_W-1:0] zero9[9];
        logic [OUT_W-1:0] axis9[9];
        coord_t c[9];
        int kind;
        zero9 = '{default: '0};
        axis9 = '{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, -16'sd16384};
        // all zero, target on position at extremes, up zero, up along forward
        add_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, zero9, 1'b1, 0);
        add_row('{MX, MN, MX, MX, MN, MX, ONE, ONE, ONE}, 1, zero9, 1'b1, 0);
        add_row('{MN, MN, MN, MN, MN, MN, MX, MX, MX}, 1, zero9, 1'b1, 0);
        add_row('{0, 0, 0, 0, 0, -ONE, 0, 0, 0}, 1, zero9, 1'b1, 0);
        add_row('{0, 0, 0, ONE, 0, 0, 5 * ONE, 0, 0}, 1, zero9, 1'b1, 0);
        add_row('{0, 0, 0, 0, -ONE, 0, 0, MN, 0}, 1, zero9, 1'b1, 0);
        add_row('{0, 0, 0, 0, 0, -ONE, 0, ONE, 0}, 1, axis9, 1'b0, 0);
        add_row('{MX, MX, MX, 0, 0, MX - ONE, 0, MX, 0}, 0, zero9, 1'b0, 0);
        add_row('{MN, MN, MN, MX, MX, MX, MX, MN, MX}, 0, zero9, 1'b0, 0);
        add_row('{MX, MX, MX, MN, MN, MN, MN, MX, MN}, 0, zero9, 1'b0, 0);
        add_row('{MN, 0, MX, MX, 0, MN, 0, MN, 1}, 0, zero9, 1'b0, 0);
        add_row('{1, 0, 0, 0, 1, 0, 0, 0, 1}, 0, zero9, 1'b0, 0);
        add_row('{-1, -1, -1, -1, -1, -1, -1, -1, -1}, 0, zero9, 1'b0, 0);
        add_row('{ONE, 2 * ONE, 3 * ONE, -ONE, 7, MX, -5, 9, MN}, 0, zero9, 1'b0, 0);
        n_direct = stim_q.size();
        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(3);
            for (int i = 0; i < 9; i++) c[i] = rand_coord(kind);
            case ($urandom_range(19))
                0: for (int i = 0; i < 3; i++) c[3+i] = c[i];
                1: for (int i = 0; i < 3; i++) c[6+i] = '0;
                2: begin
                    for (int i = 0; i < 6; i++) c[i] = rand_coord(1);
                    for (int i = 0; i < 3; i++) c[6+i] = (c[3+i] - c[i]) * -3;
                end
                default: ;
            endcase
            add_row(c, 0, zero9, 1'b0, n == 0 || n == N_RANDOM / 2);
        end
    endfunction

    function automatic int idle_pct(bit rx_side);
        int ph;
        if (next_idx <= n_direct) return 0;
        ph = (next_idx - n_direct) * 4 / (N_RANDOM + 1);
        case (ph)
            1: return rx_side ? 0 : 76;
            2: return rx_side ? 76 : 0;
            3: return 14;
            default: return 0;
        endcase
    endfunction

    // receiver hold-off counted on its own
    always @(posedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (!hold_done && next_idx >= n_direct + N_RANDOM / 4) begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        basis_t want;
        bit drain_wait;
        cycles <= cycles + 1;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (basis_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    failed = 1'b1;
                end else begin
                    want = basis_q.pop_front();
                    for (int i = 0; i < 9; i++) check_field(field_names[i], want.m[i], m_f[i]);
                    check_field("degenerate", 16'(want.degen), 16'(m_degenerate));
                end
            end
            if (s_valid && s_ready) begin
                if (stim_q[next_idx-1].typed) begin
                    want.m     = stim_q[next_idx-1].m;
                    want.degen = stim_q[next_idx-1].degen;
                end else begin
                    want = look_at_basis(s_c);
                end
                basis_q.push_back(want);
            end
            // hold the beat until taken
            if (!(s_valid && !s_ready)) begin
                drain_wait = next_idx < stim_q.size() && stim_q[next_idx].drain
                             && basis_q.size() != 0;
                if (next_idx < stim_q.size() && !drain_wait
                    && $urandom_range(99) >= idle_pct(1'b0)) begin
                    s_c      <= stim_q[next_idx].c;
                    s_valid  <= 1'b1;
                    next_idx <= next_idx + 1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= (hold_cnt == 0) && ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    always @(posedge aclk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("** look_at_rotation_basis_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        wait (next_idx == stim_q.size() && !s_valid);
        wait (basis_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (!failed && basis_q.size() == 0) begin
            $display("** look_at_rotation_basis_unit: PASSED **");
        end else begin
            $display("** look_at_rotation_basis_unit: FAILED **");
        end
        $finish;
    end

endmodule
